// ----- rtl/core/tsi_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package tsi_pkg;

  localparam int MAX_SPAN  = 64;
  localparam int CNT_W     = 7;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 32;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_STEP = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LIGHT_STEP = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_S_STEP     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_T_STEP     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WHOLE_STEP = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_WIDTH  = 3'd5;

  localparam logic [12:0] ROW_WIDTH_RESET = 13'd320;

  // span actions
  localparam logic ACT_START    = 1'b0;
  localparam logic ACT_CONTINUE = 1'b1;

  typedef struct packed {
    logic               action;
    logic [23:0]        frame_offset;
    logic [23:0]        depth_offset;
    logic [23:0]        texel_start;
    logic [15:0]        s_fraction;
    logic [15:0]        t_fraction;
    logic signed [31:0] light_start;
    logic signed [31:0] inverse_depth;
    logic [CNT_W-1:0]   pixel_count;
    logic               textured;
    logic [7:0]         solid_colour;
  } in_t;

  typedef struct packed {
    logic [23:0]        pixel_frame_offset;
    logic [23:0]        pixel_depth_offset;
    logic [23:0]        texel_address;
    logic               fetch_texel;
    logic [7:0]         colour_index;
    logic [7:0]         light_row;
    logic signed [15:0] pixel_depth;
    logic               last_pixel;
  } out_t;

  typedef struct packed {
    logic signed [31:0] depth_step_x;
    logic signed [31:0] light_step_x;
    logic [15:0]        s_fraction_step;
    logic [15:0]        t_fraction_step;
    logic signed [20:0] texel_whole_step;
    logic [12:0]        texture_row_width;
  } cfg_t;

  typedef struct packed {
    logic [23:0] frame_offset;
    logic [23:0] depth_offset;
    logic [23:0] texel;
    logic [15:0] s_fraction;
    logic [15:0] t_fraction;
    logic [31:0] light;
    logic [31:0] inverse_depth;
    logic        textured;
    logic [7:0]  colour;
  } span_t;

endpackage
`default_nettype wire

// ----- rtl/core/tsi_step.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Per-pixel stepping unit, reused for every pixel of a span.
module tsi_step import tsi_pkg::*; (
  input  wire span_t cur,
  input  wire cfg_t  cfg,
  output span_t      nxt
);

  logic [16:0] s_sum;
  logic [16:0] t_sum;
  logic [23:0] whole24;
  logic [23:0] row_add;
  logic [23:0] texel_sum;

  always_comb begin
    s_sum   = {1'b0, cur.s_fraction} + {1'b0, cfg.s_fraction_step};
    t_sum   = {1'b0, cur.t_fraction} + {1'b0, cfg.t_fraction_step};
    whole24 = {{3{cfg.texel_whole_step[20]}}, cfg.texel_whole_step};
    row_add = t_sum[16] ? {11'd0, cfg.texture_row_width} : 24'd0;
    texel_sum = cur.texel + whole24 + {23'd0, s_sum[16]} + row_add;

    nxt               = cur;
    nxt.frame_offset  = cur.frame_offset + 24'd1;
    nxt.depth_offset  = cur.depth_offset + 24'd1;
    nxt.inverse_depth = cur.inverse_depth + cfg.depth_step_x;
    nxt.light         = cur.light + cfg.light_step_x;
    nxt.s_fraction    = s_sum[15:0];
    nxt.t_fraction    = t_sum[15:0];
    // solid spans hold the texel address
    if (cur.textured) begin
      nxt.texel = texel_sum;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/textured_span_interpolator_core.sv -----
// The accept edge loads the span register; pixels are then registered into out_data
// as output slots free up. Throughput: one pixel per cycle while out_ready stays high;
// counts saturate to 64, and a new item is taken only once the span is done.
// The rate is set by the single stepping unit, which advances the span once per pixel.
// Reset (rst_n low, synchronous): span state cleared, registers to defaults
// (row width 320, others zero), no output pending.
`timescale 1ns / 1ps
`default_nettype none
module textured_span_interpolator_core import tsi_pkg::*; (
  input  wire                  clk,
  input  wire                  rst_n,
  // input transactions
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire in_t             in_data,
  // pixel transactions
  output logic                 out_valid,
  input  wire                  out_ready,
  output out_t                 out_data,
  // configuration writes
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CFG_DATA_W-1:0] cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t           state_r, state_nxt;
  cfg_t             cfg_r;
  span_t            span_r, span_nxt;
  span_t            span_step;
  logic [CNT_W-1:0] remain_r, remain_nxt;
  logic [CNT_W-1:0] count_sat;
  out_t             out_r, out_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             in_fire;
  logic             slot_free;

  // ---------------------------------------------------------------
  // Configuration registers; unknown indexes are dropped.
  // ---------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.depth_step_x      <= '0;
      cfg_r.light_step_x      <= '0;
      cfg_r.s_fraction_step   <= '0;
      cfg_r.t_fraction_step   <= '0;
      cfg_r.texel_whole_step  <= '0;
      cfg_r.texture_row_width <= ROW_WIDTH_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DEPTH_STEP: cfg_r.depth_step_x      <= cfg_data;
        REG_LIGHT_STEP: cfg_r.light_step_x      <= cfg_data;
        REG_S_STEP:     cfg_r.s_fraction_step   <= cfg_data[15:0];
        REG_T_STEP:     cfg_r.t_fraction_step   <= cfg_data[15:0];
        REG_WHOLE_STEP: cfg_r.texel_whole_step  <= cfg_data[20:0];
        REG_ROW_WIDTH:  cfg_r.texture_row_width <= cfg_data[12:0];
        default: ;
      endcase
    end
  end

  // Shared stepping unit: next interpolant set for the current pixel.
  tsi_step u_step (
    .cur (span_r),
    .cfg (cfg_r),
    .nxt (span_step)
  );

  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  // output register can take a pixel when empty or being drained
  assign slot_free = !out_valid_r || out_ready;

  always_comb begin
    count_sat = (in_data.pixel_count > CNT_W'(MAX_SPAN)) ? CNT_W'(MAX_SPAN)
                                                         : in_data.pixel_count;
  end

  // ---------------------------------------------------------------
  // Sequencer: load or resume a span, then emit one pixel per free
  // output slot and step the span after each one.
  // ---------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    span_nxt      = span_r;
    remain_nxt    = remain_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ready;

    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_data.action == ACT_START) begin
            span_nxt.frame_offset  = in_data.frame_offset;
            span_nxt.depth_offset  = in_data.depth_offset;
            span_nxt.texel         = in_data.texel_start;
            span_nxt.s_fraction    = in_data.s_fraction;
            span_nxt.t_fraction    = in_data.t_fraction;
            span_nxt.light         = in_data.light_start;
            span_nxt.inverse_depth = in_data.inverse_depth;
            span_nxt.textured      = in_data.textured;
            span_nxt.colour        = in_data.solid_colour;
          end
          remain_nxt = count_sat;
          // zero count: state is loaded but nothing goes out
          if (count_sat != '0) begin
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (slot_free) begin
          out_nxt.pixel_frame_offset = span_r.frame_offset;
          out_nxt.pixel_depth_offset = span_r.depth_offset;
          out_nxt.texel_address      = span_r.textured ? span_r.texel : 24'd0;
          out_nxt.fetch_texel        = span_r.textured;
          out_nxt.colour_index       = span_r.textured ? 8'd0 : span_r.colour;
          out_nxt.light_row          = span_r.light[15:8];
          out_nxt.pixel_depth        = span_r.inverse_depth[31:16];
          out_nxt.last_pixel         = (remain_r == CNT_W'(1));
          out_valid_nxt              = 1'b1;
          span_nxt                   = span_step;
          remain_nxt                 = remain_r - CNT_W'(1);
          if (remain_r == CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      span_r      <= '0;
      remain_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      span_r      <= span_nxt;
      remain_r    <= remain_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // pixel payload needs no reset
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule
`default_nettype wire

// ----- rtl/core/tsi_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
module tsi_checker import tsi_pkg::*; (
  input wire                  clk,
  input wire                  rst_n,
  input wire                  in_valid,
  input wire                  in_ready,
  input wire in_t             in_data,
  input wire                  out_valid,
  input wire                  out_ready,
  input wire out_t            out_data
);

  // stalled pixel holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("pixel changed while stalled");

  // a span with pixels closes the input side
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_data.pixel_count != '0) |=> !in_ready)
    else $error("input accepted during span");

  // mid-span pixel means the span is still running
  a_mid_span: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.last_pixel |-> !in_ready)
    else $error("ready before span end");

  // mode fields agree
  a_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.fetch_texel ? (out_data.colour_index == 8'd0)
                                        : (out_data.texel_address == 24'd0)))
    else $error("mode fields inconsistent");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("pixel valid after reset");

endmodule

bind textured_span_interpolator_core tsi_checker u_tsi_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
`default_nettype wire

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
// Span interpolator bench: directed spans first, then random spans under
// several register settings. Every pixel transaction is checked against a
// local predictor of the span stepping, in order, field by field.
module tb_top;
  import tsi_pkg::*;

  localparam int IDLE_LIMIT   = 2000; // cycles without any transaction
  localparam int DRAIN_CYCLES = 8;    // slack after the last expected pixel
  localparam int REPORT_MAX   = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;

  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = REG_DEPTH_STEP;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state: span interpolants and register copy
  span_t span_st;
  cfg_t  regs;
  out_t  pixel_q[$];

  int mismatches = 0;
  int idle_cycles = 0;

  // receiver stall pattern
  logic [9:0] ready_phase = '0;
  int         hold_cnt = 0;

  always #5 clk = ~clk;

  textured_span_interpolator_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------
  // Predictor: emit one expected pixel per count, then step the span.
  // ---------------------------------------------------------------------
  task automatic predict_span(in_t it);
    int          n;
    out_t        px;
    logic [16:0] s_sum;
    logic [16:0] t_sum;
    logic [23:0] step24;
    // a continue transaction keeps the stored span and ignores the fields
    if (it.action == ACT_START) begin
      span_st.frame_offset  = it.frame_offset;
      span_st.depth_offset  = it.depth_offset;
      span_st.texel         = it.texel_start;
      span_st.s_fraction    = it.s_fraction;
      span_st.t_fraction    = it.t_fraction;
      span_st.light         = it.light_start;
      span_st.inverse_depth = it.inverse_depth;
      span_st.textured      = it.textured;
      span_st.colour        = it.solid_colour;
    end
    n = (it.pixel_count > MAX_SPAN) ? MAX_SPAN : int'(it.pixel_count);
    step24 = {{3{regs.texel_whole_step[20]}}, regs.texel_whole_step};
    for (int k = 0; k < n; k++) begin
      px.pixel_frame_offset = span_st.frame_offset;
      px.pixel_depth_offset = span_st.depth_offset;
      px.texel_address      = span_st.textured ? span_st.texel : 24'd0;
      px.fetch_texel        = span_st.textured;
      px.colour_index       = span_st.textured ? 8'd0 : span_st.colour;
      px.light_row          = span_st.light[15:8];
      px.pixel_depth        = span_st.inverse_depth[31:16];
      px.last_pixel         = (k == n - 1);
      pixel_q.push_back(px);

      span_st.frame_offset  = span_st.frame_offset + 24'd1;
      span_st.depth_offset  = span_st.depth_offset + 24'd1;
      span_st.inverse_depth = span_st.inverse_depth + regs.depth_step_x;
      span_st.light         = span_st.light + regs.light_step_x;
      s_sum = {1'b0, span_st.s_fraction} + {1'b0, regs.s_fraction_step};
      t_sum = {1'b0, span_st.t_fraction} + {1'b0, regs.t_fraction_step};
      span_st.s_fraction = s_sum[15:0];
      span_st.t_fraction = t_sum[15:0];
      // solid spans hold the texel address, fractions still step
      if (span_st.textured)
        span_st.texel = span_st.texel + step24 + {23'd0, s_sum[16]} +
                        (t_sum[16] ? {11'd0, regs.texture_row_width} : 24'd0);
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver helpers. All are entered right after a rising edge.
  // ---------------------------------------------------------------------
  task automatic send_span(in_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_span(it);
  endtask

  // sender pause until every expected pixel is back, plus slack for
  // zero-count transactions that leave nothing to wait on
  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pixel_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // random bits above a narrow register, the block keeps the low ones
  function automatic logic [31:0] junk_above(int w, logic [31:0] val);
    return (32'($urandom) << w) | val;
  endfunction

  task automatic set_config(cfg_t c);
    wait_drain();
    write_reg(REG_DEPTH_STEP, c.depth_step_x);
    write_reg(REG_LIGHT_STEP, c.light_step_x);
    write_reg(REG_S_STEP,     junk_above(16, {16'd0, c.s_fraction_step}));
    write_reg(REG_T_STEP,     junk_above(16, {16'd0, c.t_fraction_step}));
    write_reg(REG_WHOLE_STEP, junk_above(21, {11'd0, c.texel_whole_step}));
    write_reg(REG_ROW_WIDTH,  junk_above(13, {19'd0, c.texture_row_width}));
    cfg_we <= 1'b0;
    @(posedge clk);
    regs = c;
  endtask

  // ---------------------------------------------------------------------
  // Random content
  // ---------------------------------------------------------------------
  function automatic logic [31:0] pick_word();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0;
      3: return 32'hFFFF_FFFF;
      4: return 32'($urandom_range(0, 4095)) - 32'd2048;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] pick_frac();
    case ($urandom_range(0, 3))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic cfg_t rand_regs();
    cfg_t c;
    c.depth_step_x    = pick_word();
    c.light_step_x    = pick_word();
    c.s_fraction_step = pick_frac();
    c.t_fraction_step = pick_frac();
    case ($urandom_range(0, 4))
      0: c.texel_whole_step = 21'h10_0000;
      1: c.texel_whole_step = 21'h0F_FFFF;
      2: c.texel_whole_step = 21'd0;
      3: c.texel_whole_step = 21'($urandom_range(0, 63)) - 21'd32;
      default: c.texel_whole_step = 21'($urandom);
    endcase
    case ($urandom_range(0, 6))
      0: c.texture_row_width = 13'd1;
      1: c.texture_row_width = 13'd4096;
      2: c.texture_row_width = ROW_WIDTH_RESET;
      3: c.texture_row_width = 13'd0;
      4: c.texture_row_width = 13'h1FFF;
      default: c.texture_row_width = 13'($urandom);
    endcase
    return c;
  endfunction

  // mostly short spans, some full, a few over the limit, some empty
  function automatic logic [CNT_W-1:0] rand_count();
    case ($urandom_range(0, 9))
      0: return 7'd0;
      1: return 7'($urandom_range(65, 127));
      2, 3: return 7'($urandom_range(9, 64));
      default: return 7'($urandom_range(1, 8));
    endcase
  endfunction

  function automatic in_t rand_span(logic act);
    in_t it;
    it.action        = act;
    it.frame_offset  = 24'($urandom);
    it.depth_offset  = 24'($urandom);
    it.texel_start   = 24'($urandom);
    it.s_fraction    = 16'($urandom);
    it.t_fraction    = 16'($urandom);
    it.light_start   = $urandom;
    it.inverse_depth = $urandom;
    it.pixel_count   = rand_count();
    it.textured      = 1'($urandom_range(0, 1));
    it.solid_colour  = 8'($urandom);
    // now and then start right below the 24-bit wrap
    if ($urandom_range(0, 7) == 0) begin
      it.frame_offset = 24'hFF_FFFF - 24'($urandom_range(0, 8));
      it.texel_start  = 24'hFF_FFFF - 24'($urandom_range(0, 8));
    end
    return it;
  endfunction

  // ---------------------------------------------------------------------
  // Directed tests
  // ---------------------------------------------------------------------

  // continue from the reset state, then plain starts in both modes
  task automatic test_reset_and_modes();
    in_t it;
    it = rand_span(ACT_CONTINUE);
    it.pixel_count = 7'd3;
    send_span(it);
    it = '1;
    it.action = ACT_START;
    it.pixel_count = 7'd6;
    send_span(it);
    it = '0;
    it.action = ACT_START;
    it.pixel_count = 7'd4;
    it.solid_colour = 8'hA5;
    send_span(it);
  endtask

  // extreme steps: every interpolant wraps, fractions carry each pixel
  task automatic test_field_extremes();
    cfg_t c;
    in_t  it;
    c.depth_step_x      = 32'h7FFF_FFFF;
    c.light_step_x      = 32'h8000_0000;
    c.s_fraction_step   = 16'hFFFF;
    c.t_fraction_step   = 16'hFFFF;
    c.texel_whole_step  = 21'h10_0000;
    c.texture_row_width = 13'd4096;
    set_config(c);
    it = '1;
    it.action = ACT_START;
    it.pixel_count = 7'd8;
    send_span(it);
    it = '0;
    it.action = ACT_START;
    it.pixel_count = 7'd8;
    it.textured = 1'b1;
    send_span(it);
    it = rand_span(ACT_CONTINUE);
    it.pixel_count = 7'd5;
    send_span(it);
    // solid span: texel held while the fractions keep stepping
    it = '1;
    it.action = ACT_START;
    it.textured = 1'b0;
    it.pixel_count = 7'd6;
    send_span(it);
    it = rand_span(ACT_CONTINUE);
    it.pixel_count = 7'd4;
    send_span(it);
  endtask

  // empty transactions: a start still loads the span
  task automatic test_zero_count();
    in_t it;
    it = rand_span(ACT_START);
    it.textured = 1'b1;
    it.pixel_count = 7'd0;
    send_span(it);
    it = rand_span(ACT_CONTINUE);
    it.pixel_count = 7'd3;
    send_span(it);
    it = rand_span(ACT_CONTINUE);
    it.pixel_count = 7'd0;
    send_span(it);
  endtask

  // counts above the span limit are cut to a full span
  task automatic test_saturation();
    in_t it;
    it = rand_span(ACT_START);
    it.pixel_count = 7'h7F;
    send_span(it);
    it = rand_span(ACT_CONTINUE);
    it.pixel_count = 7'd65;
    send_span(it);
    it = rand_span(ACT_CONTINUE);
    it.pixel_count = 7'd64;
    send_span(it);
    it = rand_span(ACT_CONTINUE);
    it.pixel_count = 7'd1;
    send_span(it);
  endtask

  // row width zero and above the texture range is added as written
  task automatic test_row_width_edges();
    cfg_t c;
    in_t  it;
    c = '0;
    c.t_fraction_step   = 16'h8000;
    c.texel_whole_step  = 21'h0F_FFFF;
    c.texture_row_width = 13'd0;
    set_config(c);
    it = rand_span(ACT_START);
    it.textured = 1'b1;
    it.t_fraction = 16'h8000;
    it.pixel_count = 7'd6;
    send_span(it);
    c.texture_row_width = 13'h1FFF;
    c.s_fraction_step = 16'h8001;
    set_config(c);
    it.pixel_count = 7'd6;
    send_span(it);
    c.texture_row_width = 13'd1;
    set_config(c);
    it = rand_span(ACT_CONTINUE);
    it.pixel_count = 7'd5;
    send_span(it);
  endtask

  // ---------------------------------------------------------------------
  // Random spans: start-then-continue runs, bursty sender
  // ---------------------------------------------------------------------
  task automatic test_random_spans();
    int burst_left;
    int gap;
    in_t it;
    burst_left = 0;
    for (int phase = 0; phase < 6; phase++) begin
      set_config(rand_regs());
      for (int i = 0; i < 19; i++) begin
        if (burst_left == 0) begin
          gap = $urandom_range(0, 10);
          if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          burst_left = $urandom_range(1, 8);
        end
        burst_left--;
        // hold off mid-phase until the pipe is empty
        if (phase == 2 && i == 9) wait_drain();
        it = rand_span(($urandom_range(0, 99) < 65) ? ACT_START : ACT_CONTINUE);
        send_span(it);
      end
    end
  endtask

  // ---------------------------------------------------------------------
  // Receiver: always ready, random stalls, and long stall runs in turn
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    ready_phase <= ready_phase + 10'd1;
    case (ready_phase[9:8])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= ($urandom_range(0, 3) != 0);
      2'd2: begin
        if (hold_cnt == 0) begin
          out_ready <= ~out_ready;
          hold_cnt  <= out_ready ? $urandom_range(1, 20) : $urandom_range(1, 12);
        end else begin
          hold_cnt <= hold_cnt - 1;
        end
      end
      default: out_ready <= 1'($urandom_range(0, 1));
    endcase
  end

  function automatic string pix_text(out_t p);
    return $sformatf("fo=%h do=%h tx=%h fetch=%b col=%h row=%h z=%h last=%b",
                     p.pixel_frame_offset, p.pixel_depth_offset, p.texel_address,
                     p.fetch_texel, p.colour_index, p.light_row, p.pixel_depth,
                     p.last_pixel);
  endfunction

  // ---------------------------------------------------------------------
  // Pixel checker: each accepted pixel against the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    out_t exp_px;
    logic bad;
    if (rst_n && out_valid && out_ready) begin
      if (pixel_q.size() == 0) begin
        if (mismatches < REPORT_MAX)
          $display("unexpected pixel transaction: %s", pix_text(out_data));
        mismatches++;
      end else begin
        exp_px = pixel_q.pop_front();
        bad = (out_data.pixel_frame_offset !== exp_px.pixel_frame_offset) ||
              (out_data.pixel_depth_offset !== exp_px.pixel_depth_offset) ||
              (out_data.texel_address      !== exp_px.texel_address)      ||
              (out_data.fetch_texel        !== exp_px.fetch_texel)        ||
              (out_data.colour_index       !== exp_px.colour_index)       ||
              (out_data.light_row          !== exp_px.light_row)          ||
              (out_data.pixel_depth        !== exp_px.pixel_depth)        ||
              (out_data.last_pixel         !== exp_px.last_pixel);
        if (bad) begin
          if (mismatches < REPORT_MAX) begin
            $display("pixel mismatch at %0t", $realtime);
            $display("  expected %s", pix_text(exp_px));
            $display("  actual   %s", pix_text(out_data));
          end
          mismatches++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  initial begin
    regs = '0;
    regs.texture_row_width = ROW_WIDTH_RESET;
    span_st = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_and_modes();
    test_field_extremes();
    test_zero_count();
    test_saturation();
    test_row_width_edges();
    test_random_spans();

    wait_drain();
    if (mismatches == 0 && pixel_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- files.f -----
rtl/core/tsi_pkg.sv
rtl/core/tsi_step.sv
rtl/core/textured_span_interpolator_core.sv
rtl/core/tsi_checker.sv
dv/tb_top.sv
